>>> src/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types, character codes and the power-of-ten table for the signed
// binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int POS_W   = 5;
    localparam int WSEL_W  = 2;
    localparam int DIGIT_W = 4;
    localparam int CODE_W  = 6;
    localparam int POW_W   = 64;

    localparam logic [CODE_W-1:0] CODE_ZERO  = 6'd48;
    localparam logic [CODE_W-1:0] CODE_MINUS = 6'd45;

    // weight select for the first trial of a digit (weight 8)
    localparam logic [WSEL_W-1:0] WSEL_FIRST = 2'd3;
    localparam logic [WSEL_W-1:0] WSEL_LAST  = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_TRIAL
    } state_t;

    typedef struct packed {
        logic               load;
        logic               trial;
        logic [POS_W-1:0]   pos;
        logic [WSEL_W-1:0]  wsel;
    } unit_ctrl_t;

    function automatic logic [POW_W-1:0] pow10(input logic [POS_W-1:0] k);
        logic [POW_W-1:0] p;
        case (k)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            5'd18:   p = 64'd1000000000000000000;
            default: p = 64'd0;
        endcase
        return p;
    endfunction

    // decimal digits of 2^(bits-1), the largest magnitude at that width
    function automatic int num_digits(input int bits);
        int               n;
        logic [POW_W-1:0] p;
        n = 1;
        p = 64'd1 << (bits - 1);
        for (int k = 1; k < 19; k++)
        begin
            if (pow10(POS_W'(k)) <= p)
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

endpackage

>>> src/sbda_sub_unit.sv
// ----------------------------------------------------------------------------
// sbda_sub_unit
// Remainder register with one shared compare and subtract against a weighted
// power of ten; builds each decimal digit one bit per cycle.
// ----------------------------------------------------------------------------
module sbda_sub_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbda_pkg::unit_ctrl_t                ctrl,
    input  logic [VALUE_BITS-1:0]               value,
    output logic [sbda_pkg::DIGIT_W-1:0]        digit
);

    localparam int EXT_W = sbda_pkg::POW_W + 3;

    logic [VALUE_BITS-1:0]            rem_reg;
    logic [VALUE_BITS-1:0]            rem_next;
    logic [sbda_pkg::DIGIT_W-1:0]     digit_reg;
    logic [sbda_pkg::DIGIT_W-1:0]     digit_next;
    logic [sbda_pkg::DIGIT_W-1:0]     digit_base;
    logic [EXT_W-1:0]                 weight;
    logic [EXT_W-1:0]                 rem_ext;
    logic [EXT_W-1:0]                 diff;
    logic                             ge;
    logic                             negative;

    assign negative = value[VALUE_BITS-1];

    // weight is 10^pos scaled by 1, 2, 4 or 8
    assign weight  = {3'b000, sbda_pkg::pow10(ctrl.pos)} << ctrl.wsel;
    assign rem_ext = EXT_W'(rem_reg);
    assign ge      = rem_ext >= weight;
    assign diff    = rem_ext - weight;

    always_comb
    begin
        digit_base = (ctrl.wsel == sbda_pkg::WSEL_FIRST) ? '0 : digit_reg;
        digit_next = digit_base | (sbda_pkg::DIGIT_W'(ge) << ctrl.wsel);
        rem_next   = rem_reg;
        if (ctrl.load)
        begin
            // magnitude as unsigned, so the most negative value needs no case
            rem_next = negative ? (~value + 1'b1) : value;
        end
        else if (ctrl.trial && ge)
        begin
            rem_next = diff[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (ctrl.trial)
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_next;

    a_no_load_and_trial: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.load && ctrl.trial))
        else $error("load and trial together");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.trial && ctrl.wsel == sbda_pkg::WSEL_LAST |-> digit <= 4'd9)
        else $error("digit out of range");

    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.trial |=> rem_reg <= $past(rem_reg))
        else $error("remainder grew on a trial");

endmodule

>>> src/sbda_seq.sv
// ----------------------------------------------------------------------------
// sbda_seq
// Sequencer: walks digit positions and weights, suppresses leading zeros and
// drives the registered character output.
// ----------------------------------------------------------------------------
module sbda_seq #(
    parameter int NUM_DIGITS = 19
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                negative,
    input  logic [sbda_pkg::DIGIT_W-1:0]        digit,
    output sbda_pkg::unit_ctrl_t                ctrl,
    output logic                                busy,
    output logic                                char_strobe,
    output logic [sbda_pkg::CODE_W-1:0]         char_code,
    output logic                                last_char
);

    localparam logic [sbda_pkg::POS_W-1:0] POS_TOP = sbda_pkg::POS_W'(NUM_DIGITS - 1);

    sbda_pkg::state_t                  state_reg;
    sbda_pkg::state_t                  state_next;
    logic [sbda_pkg::POS_W-1:0]        pos_reg;
    logic [sbda_pkg::POS_W-1:0]        pos_next;
    logic [sbda_pkg::WSEL_W-1:0]       wsel_reg;
    logic [sbda_pkg::WSEL_W-1:0]       wsel_next;
    logic                              seen_reg;
    logic                              seen_next;
    logic                              strobe_reg;
    logic                              strobe_next;
    logic [sbda_pkg::CODE_W-1:0]       code_reg;
    logic [sbda_pkg::CODE_W-1:0]       code_next;
    logic                              last_reg;
    logic                              last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sbda_pkg::ST_IDLE;
            pos_reg    <= '0;
            wsel_reg   <= '0;
            seen_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            wsel_reg   <= wsel_next;
            seen_reg   <= seen_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        wsel_next   = wsel_reg;
        seen_next   = seen_reg;
        strobe_next = 1'b0;
        code_next   = code_reg;
        last_next   = last_reg;
        ctrl.load   = 1'b0;
        ctrl.trial  = 1'b0;
        ctrl.pos    = pos_reg;
        ctrl.wsel   = wsel_reg;
        case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    pos_next   = POS_TOP;
                    wsel_next  = sbda_pkg::WSEL_FIRST;
                    seen_next  = 1'b0;
                    state_next = negative ? sbda_pkg::ST_SIGN : sbda_pkg::ST_TRIAL;
                end
            end
            sbda_pkg::ST_SIGN:
            begin
                strobe_next = 1'b1;
                code_next   = sbda_pkg::CODE_MINUS;
                last_next   = 1'b0;
                state_next  = sbda_pkg::ST_TRIAL;
            end
            sbda_pkg::ST_TRIAL:
            begin
                ctrl.trial = 1'b1;
                if (wsel_reg == sbda_pkg::WSEL_LAST)
                begin
                    // leading zeros dropped, but the units digit always goes out
                    if (digit != '0 || seen_reg || pos_reg == '0)
                    begin
                        strobe_next = 1'b1;
                        code_next   = sbda_pkg::CODE_ZERO + sbda_pkg::CODE_W'(digit);
                        last_next   = (pos_reg == '0);
                        seen_next   = 1'b1;
                    end
                    if (pos_reg == '0)
                    begin
                        state_next = sbda_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pos_next  = pos_reg - 1'b1;
                        wsel_next = sbda_pkg::WSEL_FIRST;
                    end
                end
                else
                begin
                    wsel_next = wsel_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != sbda_pkg::ST_IDLE);
    assign char_strobe = strobe_reg;
    assign char_code   = code_reg;
    assign last_char   = last_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_more_to_come: assert property (@(posedge clk) disable iff (!rst_n)
        char_strobe && !last_char |-> busy)
        else $error("run not finished but block idle");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_strobe && last_char |=> !char_strobe)
        else $error("character straight after end of run");

    a_gap_after_sign: assert property (@(posedge clk) disable iff (!rst_n)
        char_strobe && char_code == sbda_pkg::CODE_MINUS |=> !char_strobe && busy)
        else $error("sign not followed by digit trials");

endmodule

>>> src/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed two's complement integer to decimal ascii text, most
// significant character first.
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on the rising edge where start is high and busy is low;
//   value carries the integer in its low VALUE_BITS bits, bit VALUE_BITS-1
//   being the sign and the bits above ignored.
//   the text comes out on char_code, one character per char_strobe pulse,
//   each held for exactly one cycle; last_char marks the final character.
//   a negative value is led by '-', zero gives '0', no leading zeros and no
//   terminator.
// timing:
//   the '-' comes from the registered strobe and code after the sequencer has
//   passed through its sign state; then every digit position is built by a
//   compare and subtract against 8, 4, 2 and 1 times its power of ten in one
//   shared subtractor, with 19 digit positions at 64 bits.
//   leading zero positions are still walked, so the time is fixed per sign.
//   busy falls in the cycle the last character is shown.
// reset:
//   rst_n clears the sequencer and the strobe; no character is in flight.
//   the receiver cannot stall: every character is taken as it appears.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [63:0]                         value,
    output logic                                char_strobe,
    output logic [sbda_pkg::CODE_W-1:0]         char_code,
    output logic                                last_char
);

    localparam int NUM_DIGITS = sbda_pkg::num_digits(VALUE_BITS);

    sbda_pkg::unit_ctrl_t             ctrl;
    logic [sbda_pkg::DIGIT_W-1:0]     digit;
    logic [VALUE_BITS-1:0]            value_low;

    assign value_low = value[VALUE_BITS-1:0];

    sbda_sub_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_sub_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .value (value_low),
        .digit (digit)
    );

    sbda_seq #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .negative    (value_low[VALUE_BITS-1]),
        .digit       (digit),
        .ctrl        (ctrl),
        .busy        (busy),
        .char_strobe (char_strobe),
        .char_code   (char_code),
        .last_char   (last_char)
    );

endmodule
